[rtl/pmw_pkg.sv]
// ----------------------------------------------------------------------------
// pmw_pkg
// Shared types and constants of the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmw_pkg;

  // fixed field widths of the ports
  localparam int VERTEX_W    = 6;
  localparam int IN_WEIGHT_W = 16;
  localparam int TOTAL_W     = 22;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_VERTEX = 1'b1;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VERTEX_W-1:0]   START_RESET  = 6'd0;

  // result of one tree computation
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               connected;
  } tree_res_t;

  // top level sequencing
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_TREE
  } top_state_t;

  // tree engine sequencing
  typedef enum logic {
    TS_IDLE,
    TS_SCAN
  } tree_state_t;

endpackage : pmw_pkg

`default_nettype wire

[rtl/prim_mst_weight_core.sv]
// ----------------------------------------------------------------------------
// prim_mst_weight_core
// Minimum spanning tree weight of a graph loaded one edge per transaction.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle while busy is low; each is a single
// read-modify-write of its entry in the adjacency memory, with the previous
// write forwarded. The transaction marked last_edge raises busy: a drain
// state, then the tree engine runs one pass per reached vertex, the last
// pass finding no new vertex, each pass sweeping the vertex memory and one
// adjacency row at one vertex a cycle. With the start vertex out of range
// no pass runs. The result strobe is registered from the engine's done
// flag, which is itself registered at the end of the last pass; it is on
// out_valid for exactly one cycle and cannot be held off, so the receiver
// must take it then. After each result, and after reset, the adjacency
// presence bits are cleared by a sweep over all 2^(2*ceil(log2(MAX_VERTICES)))
// entries (4096 at the default) during which busy stays high; configuration
// writes are still taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module prim_mst_weight_core #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pmw_pkg::VERTEX_W-1:0]       in_edge_from,
  input  wire logic [pmw_pkg::VERTEX_W-1:0]       in_edge_to,
  input  wire logic [pmw_pkg::IN_WEIGHT_W-1:0]    in_edge_weight,
  input  wire logic                               in_edge_present,
  input  wire logic                               in_last_edge,
  output logic                                    out_valid,
  output logic [pmw_pkg::TOTAL_W-1:0]             out_total_weight,
  output logic                                    out_all_connected,
  output logic                                    out_bad_edge_seen,
  input  wire logic                               cfg_we,
  input  wire logic [pmw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pmw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pmw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = ((VW + 1) > 7) ? (VW + 1) : 7;

  top_state_t               state_r, state_nxt;
  logic [CFG_DATA_W-1:0]    vcount_r;
  logic [VERTEX_W-1:0]      startv_r;
  logic [CW-1:0]            vc_ext, eff_n;

  logic                     ld_accept, clr_en, clr_done, tree_go, bad_clr;
  logic                     bad_flag;
  logic [VW-1:0]            adj_a, adj_b;
  logic                     adj_present;
  logic [WEIGHT_BITS-1:0]   adj_weight;
  logic                     tree_done;
  tree_res_t                tree_res;

  logic                     out_valid_r;
  logic [TOTAL_W-1:0]       out_total_r;
  logic                     out_conn_r;
  logic                     out_bad_r;

  // effective vertex count
  always_comb begin
    vc_ext = CW'(vcount_r);
    if (vc_ext == '0) begin
      eff_n = CW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      eff_n = CW'(MAX_VERTICES);
    end else begin
      eff_n = vc_ext;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      startv_r <= START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_wdata;
        CFG_START_VERTEX: startv_r <= cfg_wdata[VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE: if (start && in_last_edge) begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_TREE;
      ST_TREE: if (tree_done) begin
        state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = 1'b1;
    ld_accept = 1'b0;
    clr_en    = 1'b0;
    tree_go   = 1'b0;
    bad_clr   = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        ld_accept = start;
      end
      ST_DRAIN: tree_go = 1'b1;
      ST_TREE:  bad_clr = tree_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  pmw_adj_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_adj (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_n      (eff_n),
    .ld_accept  (ld_accept),
    .ld_from    (in_edge_from),
    .ld_to      (in_edge_to),
    .ld_weight  (in_edge_weight),
    .ld_present (in_edge_present),
    .clr_en     (clr_en),
    .clr_done   (clr_done),
    .bad_clr    (bad_clr),
    .bad_flag   (bad_flag),
    .rd_a       (adj_a),
    .rd_b       (adj_b),
    .rd_present (adj_present),
    .rd_weight  (adj_weight)
  );

  pmw_tree #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_tree (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (tree_go),
    .eff_n       (eff_n),
    .start_v     (startv_r),
    .adj_present (adj_present),
    .adj_weight  (adj_weight),
    .adj_a       (adj_a),
    .adj_b       (adj_b),
    .done        (tree_done),
    .res         (tree_res)
  );

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_TREE) && tree_done;
    end
    if (tree_done) begin
      out_total_r <= tree_res.total;
      out_conn_r  <= tree_res.connected;
      out_bad_r   <= bad_flag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_weight  = out_total_r;
  assign out_all_connected = out_conn_r;
  assign out_bad_edge_seen = out_bad_r;

  // a result is a single cycle strobe
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // the closing transaction stops further loads
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_edge) |=> busy)
    else $error("block not busy after closing transaction");

  // each result is followed by the clearing sweep
  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_CLEAR))
    else $error("result without clearing sweep");

endmodule : prim_mst_weight_core

`default_nettype wire

[rtl/pmw_adj_store.sv]
// ----------------------------------------------------------------------------
// pmw_adj_store
// Adjacency memory holding one entry per unordered vertex pair (smaller
// vertex first). Loads do a read-modify-write with forwarding, a sweep
// clears the presence bits, and the tree engine reads through one port.
// ----------------------------------------------------------------------------
`default_nettype none

module pmw_adj_store #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [((($clog2(MAX_VERTICES)+1) > 7) ?
                      ($clog2(MAX_VERTICES)+1) : 7)-1:0] eff_n,
  input  wire logic                              ld_accept,
  input  wire logic [pmw_pkg::VERTEX_W-1:0]      ld_from,
  input  wire logic [pmw_pkg::VERTEX_W-1:0]      ld_to,
  input  wire logic [pmw_pkg::IN_WEIGHT_W-1:0]   ld_weight,
  input  wire logic                              ld_present,
  input  wire logic                              clr_en,
  output logic                                   clr_done,
  input  wire logic                              bad_clr,
  output logic                                   bad_flag,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   rd_a,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   rd_b,
  output logic                                   rd_present,
  output logic [WEIGHT_BITS-1:0]                 rd_weight
);
  import pmw_pkg::*;

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CW     = ((VW + 1) > 7) ? (VW + 1) : 7;
  localparam int AW     = 2 * VW;
  localparam int ADEPTH = 1 << AW;
  localparam int DW     = WEIGHT_BITS + 1;

  logic [DW-1:0] mem [ADEPTH];

  logic [CW-1:0]          a_ext, b_ext;
  logic [VW-1:0]          ld_a, ld_b, ld_lo, ld_hi;
  logic                   in_rng, ld_ok, bad_set;
  logic [AW-1:0]          ld_addr, tr_addr, rd_addr;
  logic [VW-1:0]          tr_lo, tr_hi;
  logic [DW-1:0]          rd_q_r;

  logic                   s1_valid_r;
  logic [AW-1:0]          s1_addr_r;
  logic [WEIGHT_BITS-1:0] s1_w_r;

  logic                   wl_valid_r;
  logic [AW-1:0]          wl_addr_r;
  logic [DW-1:0]          wl_data_r;

  logic [DW-1:0]          old_ent;
  logic                   s1_wr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DW-1:0]          wr_data;

  logic [AW-1:0]          clr_cnt_r;
  logic                   bad_r;

  // edge decode: range check, self loop, pair ordering
  always_comb begin
    a_ext   = CW'(ld_from);
    b_ext   = CW'(ld_to);
    in_rng  = (a_ext < eff_n) && (b_ext < eff_n);
    ld_a    = a_ext[VW-1:0];
    ld_b    = b_ext[VW-1:0];
    ld_ok   = ld_present && in_rng && (ld_from != ld_to);
    bad_set = ld_present && !in_rng;
    ld_lo   = (ld_a < ld_b) ? ld_a : ld_b;
    ld_hi   = (ld_a < ld_b) ? ld_b : ld_a;
    ld_addr = {ld_lo, ld_hi};
  end

  // tree side address, same ordering
  always_comb begin
    tr_lo   = (rd_a < rd_b) ? rd_a : rd_b;
    tr_hi   = (rd_a < rd_b) ? rd_b : rd_a;
    tr_addr = {tr_lo, tr_hi};
    rd_addr = ld_accept ? ld_addr : tr_addr;
  end

  // keep smaller weight: forward the write of the previous cycle
  always_comb begin
    old_ent = (wl_valid_r && (wl_addr_r == s1_addr_r)) ? wl_data_r : rd_q_r;
    s1_wr   = s1_valid_r && (!old_ent[DW-1] || (s1_w_r < old_ent[WEIGHT_BITS-1:0]));
  end

  // single write port: clearing sweep or load update
  always_comb begin
    wr_en   = clr_en || s1_wr;
    wr_addr = clr_en ? clr_cnt_r : s1_addr_r;
    wr_data = clr_en ? '0 : {1'b1, s1_w_r};
  end

  assign clr_done   = clr_en && (&clr_cnt_r);
  assign bad_flag   = bad_r;
  assign rd_present = rd_q_r[DW-1];
  assign rd_weight  = rd_q_r[WEIGHT_BITS-1:0];

  // memory array
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // load stage and last write record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wl_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ld_accept && ld_ok;
      wl_valid_r <= wr_en;
    end
    s1_addr_r <= ld_addr;
    s1_w_r    <= WEIGHT_BITS'(ld_weight);
    wl_addr_r <= wr_addr;
    wl_data_r <= wr_data;
  end

  // clearing sweep counter and bad edge flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      bad_r     <= 1'b0;
    end else begin
      if (clr_en) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end else begin
        clr_cnt_r <= '0;
      end
      if (bad_clr) begin
        bad_r <= 1'b0;
      end else if (ld_accept && bad_set) begin
        bad_r <= 1'b1;
      end
    end
  end

  // a load never lands during the clearing sweep
  a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |-> !s1_valid_r)
    else $error("load update overlaps clearing sweep");

endmodule : pmw_adj_store

`default_nettype wire

[rtl/pmw_tree.sv]
// ----------------------------------------------------------------------------
// pmw_tree
// Prim tree engine. Keys and tree marks sit in a vertex memory; each pass
// relaxes the row of the newest tree vertex and finds the next minimum key
// in the same sweep, one vertex per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmw_tree #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              go,
  input  wire logic [((($clog2(MAX_VERTICES)+1) > 7) ?
                      ($clog2(MAX_VERTICES)+1) : 7)-1:0] eff_n,
  input  wire logic [pmw_pkg::VERTEX_W-1:0]      start_v,
  input  wire logic                              adj_present,
  input  wire logic [WEIGHT_BITS-1:0]            adj_weight,
  output logic [$clog2(MAX_VERTICES)-1:0]        adj_a,
  output logic [$clog2(MAX_VERTICES)-1:0]        adj_b,
  output logic                                   done,
  output pmw_pkg::tree_res_t                     res
);
  import pmw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = ((VW + 1) > 7) ? (VW + 1) : 7;
  localparam int KW = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  logic [KW:0] key_mem [MAX_VERTICES];

  tree_state_t          state_r, state_nxt;
  logic [VW-1:0]        best_r, best_nxt;
  logic [CW-1:0]        iv_r, iv_nxt;
  logic                 first_r, first_nxt;
  logic                 dv_r, dv_nxt;
  logic [VW-1:0]        vd_r, vd_nxt;
  logic [KW-1:0]        min_key_r, min_key_nxt;
  logic [VW-1:0]        min_v_r, min_v_nxt;
  logic                 found_r, found_nxt;
  logic [TOTAL_W-1:0]   sum_r, sum_nxt;
  logic [CW-1:0]        reached_r, reached_nxt;
  logic                 done_r, done_nxt;
  tree_res_t            res_r, res_nxt;
  logic [KW:0]          key_q_r;

  logic [CW-1:0]        start_ext;
  logic                 start_ok;
  logic                 issue, pass_end;
  logic [KW:0]          cur;
  logic                 cur_in, is_best, relax, new_in, cand;
  logic [KW-1:0]        cur_k, w_ext, new_k;
  logic [KW+TOTAL_W-1:0] mk_ext;

  assign start_ext = CW'(start_v);
  assign start_ok  = start_ext < eff_n;
  assign issue     = (state_r == TS_SCAN) && (iv_r < eff_n);
  assign pass_end  = (state_r == TS_SCAN) && !issue && !dv_r;
  assign mk_ext    = {{TOTAL_W{1'b0}}, min_key_r};

  // relaxation of one vertex against the newest tree vertex
  always_comb begin
    cur     = first_r ? {1'b0, KEY_INF} : key_q_r;
    cur_in  = cur[KW];
    cur_k   = cur[KW-1:0];
    is_best = (vd_r == best_r);
    w_ext   = KW'(adj_weight);
    relax   = !cur_in && !is_best && adj_present && (w_ext < cur_k);
    new_k   = relax ? w_ext : cur_k;
    new_in  = cur_in || is_best;
    cand    = dv_r && !new_in && (new_k < min_key_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TS_IDLE: if (go && start_ok) begin
        state_nxt = TS_SCAN;
      end
      TS_SCAN: if (pass_end && !found_r) begin
        state_nxt = TS_IDLE;
      end
      default: state_nxt = TS_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    best_nxt    = best_r;
    iv_nxt      = iv_r;
    first_nxt   = first_r;
    dv_nxt      = 1'b0;
    vd_nxt      = iv_r[VW-1:0];
    min_key_nxt = min_key_r;
    min_v_nxt   = min_v_r;
    found_nxt   = found_r;
    sum_nxt     = sum_r;
    reached_nxt = reached_r;
    done_nxt    = 1'b0;
    res_nxt     = res_r;
    unique case (state_r)
      TS_IDLE: if (go) begin
        best_nxt    = start_ext[VW-1:0];
        iv_nxt      = '0;
        first_nxt   = 1'b1;
        min_key_nxt = KEY_INF;
        found_nxt   = 1'b0;
        sum_nxt     = '0;
        reached_nxt = CW'(1);
        if (!start_ok) begin
          done_nxt = 1'b1;
          res_nxt  = '0;
        end
      end
      TS_SCAN: begin
        dv_nxt = issue;
        if (issue) begin
          iv_nxt = iv_r + CW'(1);
        end
        if (cand) begin
          min_key_nxt = new_k;
          min_v_nxt   = vd_r;
          found_nxt   = 1'b1;
        end
        if (pass_end) begin
          if (found_r) begin
            best_nxt    = min_v_r;
            sum_nxt     = sum_r + mk_ext[TOTAL_W-1:0];
            reached_nxt = reached_r + CW'(1);
            iv_nxt      = '0;
            first_nxt   = 1'b0;
            min_key_nxt = KEY_INF;
            found_nxt   = 1'b0;
          end else begin
            done_nxt          = 1'b1;
            res_nxt.total     = sum_r;
            res_nxt.connected = (reached_r == eff_n);
          end
        end
      end
      default: ;
    endcase
  end

  assign adj_a = best_r;
  assign adj_b = iv_r[VW-1:0];
  assign done  = done_r;
  assign res   = res_r;

  // vertex memory: read ahead, write back in the cycle after the read
  always_ff @(posedge clk) begin
    key_q_r <= key_mem[iv_r[VW-1:0]];
    if (dv_r) begin
      key_mem[vd_r] <= {new_in, new_k};
    end
  end

  // engine registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      dv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      done_r  <= done_nxt;
    end
    best_r    <= best_nxt;
    iv_r      <= iv_nxt;
    first_r   <= first_nxt;
    vd_r      <= vd_nxt;
    min_key_r <= min_key_nxt;
    min_v_r   <= min_v_nxt;
    found_r   <= found_nxt;
    sum_r     <= sum_nxt;
    reached_r <= reached_nxt;
    res_r     <= res_nxt;
  end

endmodule : pmw_tree

`default_nettype wire

[test/prim_mst_weight_core_tb.sv]
// ----------------------------------------------------------------------------
// prim_mst_weight_core_tb
// Self-checking bench for the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
// Graphs are streamed one edge per transaction. The bench keeps its own copy
// of the adjacency matrix and runs Prim's algorithm on it whenever a closing
// transaction is accepted, so each tree total, connected flag and bad-edge
// flag can be checked against the strobed result. A short directed part
// covers parallel edges, self-loops, out-of-range endpoints, empty items,
// count clamping, a count lowered mid-graph and an out-of-range start.
// Random graphs then follow, mostly spanning trees with extra edges and
// some noise, under varying sender gaps and register settings.
// ----------------------------------------------------------------------------

module prim_mst_weight_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmw_pkg::*;

  localparam int NV             = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 5000;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef enum {
    ENT_EDGE,
    ENT_CFG,
    ENT_SYNC
  } entry_kind_t;

  typedef struct {
    entry_kind_t            kind;
    logic [VERTEX_W-1:0]    src;
    logic [VERTEX_W-1:0]    dst;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   present;
    logic                   closing;
    logic [CFG_INDEX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_val;
  } stim_entry_t;

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               connected;
    logic               bad;
  } mst_expect_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                   start           = 1'b0;
  logic                   busy;
  logic [VERTEX_W-1:0]    in_edge_from    = '0;
  logic [VERTEX_W-1:0]    in_edge_to      = '0;
  logic [IN_WEIGHT_W-1:0] in_edge_weight  = '0;
  logic                   in_edge_present = 1'b0;
  logic                   in_last_edge    = 1'b0;
  logic                   out_valid;
  logic [TOTAL_W-1:0]     out_total_weight;
  logic                   out_all_connected;
  logic                   out_bad_edge_seen;
  logic                   cfg_we          = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index       = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata       = '0;

  prim_mst_weight_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_edge_weight    (in_edge_weight),
    .in_edge_present   (in_edge_present),
    .in_last_edge      (in_last_edge),
    .out_valid         (out_valid),
    .out_total_weight  (out_total_weight),
    .out_all_connected (out_all_connected),
    .out_bad_edge_seen (out_bad_edge_seen),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // stimulus and expectation stores
  stim_entry_t pending[$];
  mst_expect_t results_due[$];
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fault_count  = 0;
  int unsigned stall_cycles = 0;

  // shadow of the graph and the registers
  logic [IN_WEIGHT_W-1:0] adj_w  [0:NV-1][0:NV-1];
  bit                     adj_on [0:NV-1][0:NV-1];
  bit                     bad_seen   = 1'b0;
  logic [CFG_DATA_W-1:0]  shadow_cnt = VCOUNT_RESET;
  logic [VERTEX_W-1:0]    shadow_st  = START_RESET;

  // load one edge and, on a closing transaction, grow the tree
  function automatic void mst_model_step(input logic [VERTEX_W-1:0] src,
                                         input logic [VERTEX_W-1:0] dst,
                                         input logic [IN_WEIGHT_W-1:0] w,
                                         input logic present, input logic closing);
    int unsigned n;
    int unsigned best;
    int unsigned reached;
    int unsigned v;
    bit [16:0]   vkey [0:NV-1];
    bit          in_tree [0:NV-1];
    bit [16:0]   best_key;
    bit [31:0]   sum;
    mst_expect_t exp_res;
    n = (shadow_cnt == 0) ? 1 : ((shadow_cnt > NV) ? NV : shadow_cnt);
    // edge load: out of range flags, self-loop ignored, parallel keeps minimum
    if (present) begin
      if (src >= n || dst >= n) begin
        bad_seen = 1'b1;
      end else if (src != dst && (!adj_on[src][dst] || w < adj_w[src][dst])) begin
        adj_w[src][dst]  = w;
        adj_w[dst][src]  = w;
        adj_on[src][dst] = 1'b1;
        adj_on[dst][src] = 1'b1;
      end
    end
    if (!closing) return;
    // dense minimum-key scan
    for (v = 0; v < NV; v++) begin
      vkey[v]    = 17'h10000;
      in_tree[v] = 1'b0;
    end
    sum     = 0;
    reached = 0;
    if (shadow_st < n) begin
      vkey[shadow_st] = '0;
      do begin
        best     = n;
        best_key = 17'h10000;
        for (v = 0; v < n; v++) begin
          if (!in_tree[v] && vkey[v] < best_key) begin
            best_key = vkey[v];
            best     = v;
          end
        end
        if (best < n) begin
          in_tree[best] = 1'b1;
          reached++;
          sum += best_key;
          for (v = 0; v < n; v++) begin
            if (adj_on[best][v] && !in_tree[v] && {1'b0, adj_w[best][v]} < vkey[v])
              vkey[v] = {1'b0, adj_w[best][v]};
          end
        end
      end while (best < n);
    end
    exp_res.total     = sum[TOTAL_W-1:0];
    exp_res.connected = (shadow_st < n) && (reached == n);
    exp_res.bad       = bad_seen;
    results_due.insert(results_due.size(), exp_res);
    // presence bits and the bad-edge flag start afresh for the next graph
    for (v = 0; v < NV; v++) begin
      for (best = 0; best < NV; best++) adj_on[v][best] = 1'b0;
    end
    bad_seen = 1'b0;
  endfunction

  function automatic void push_edge(input int unsigned s, input int unsigned d,
                                    input int unsigned w, input bit p, input bit c);
    stim_entry_t e;
    e.kind    = ENT_EDGE;
    e.src     = s[VERTEX_W-1:0];
    e.dst     = d[VERTEX_W-1:0];
    e.weight  = w[IN_WEIGHT_W-1:0];
    e.present = p;
    e.closing = c;
    e.cfg_idx = '0;
    e.cfg_val = '0;
    pending.insert(pending.size(), e);
    items_queued++;
  endfunction

  function automatic void push_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                   input int unsigned val);
    stim_entry_t e;
    e.kind    = ENT_CFG;
    e.src     = '0;
    e.dst     = '0;
    e.weight  = '0;
    e.present = 1'b0;
    e.closing = 1'b0;
    e.cfg_idx = idx;
    e.cfg_val = val[CFG_DATA_W-1:0];
    pending.insert(pending.size(), e);
  endfunction

  // driver: one transaction or register write per cycle from the pending queue, held while the block is busy
  always @(posedge clk) begin : drive_proc
    logic        taken;
    logic        start_nx;
    logic        we_nx;
    int unsigned idle_pct;
    stim_entry_t head;
    if (!rst_n) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        mst_model_step(in_edge_from, in_edge_to, in_edge_weight,
                       in_edge_present, in_last_edge);
        items_taken++;
        quiet_cycles = 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles++;
      end
      start_nx = start && !taken;
      we_nx    = 1'b0;
      // sender gap rate by stretch: light, heavy, none
      idle_pct = (items_taken < 300) ? 7 : ((items_taken < 600) ? 64 : 0);
      if (!start_nx && pending.size() != 0) begin
        head = pending[0];
        case (head.kind)
          ENT_EDGE: begin
            if ($urandom_range(99) >= idle_pct) begin
              in_edge_from    <= head.src;
              in_edge_to      <= head.dst;
              in_edge_weight  <= head.weight;
              in_edge_present <= head.present;
              in_last_edge    <= head.closing;
              start_nx = 1'b1;
              pending.delete(0);
            end
          end
          ENT_CFG: begin
            // registers change only once the block has gone quiet
            if (results_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              cfg_index <= head.cfg_idx;
              cfg_wdata <= head.cfg_val;
              we_nx = 1'b1;
              if (head.cfg_idx == CFG_VERTEX_COUNT) shadow_cnt = head.cfg_val;
              else shadow_st = head.cfg_val[VERTEX_W-1:0];
              pending.delete(0);
            end
          end
          default: begin
            if (results_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
              pending.delete(0);
          end
        endcase
      end
      start  <= start_nx;
      cfg_we <= we_nx;
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin : check_proc
    mst_expect_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: total %0d connected %0b bad %0b",
                   out_total_weight, out_all_connected, out_bad_edge_seen);
      end else begin
        want = results_due.pop_front();
        if (out_total_weight !== want.total || out_all_connected !== want.connected ||
            out_bad_edge_seen !== want.bad) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: total %0d/%0d connected %0b/%0b bad %0b/%0b (exp/act)",
                     want.total, out_total_weight, want.connected, out_all_connected,
                     want.bad, out_bad_edge_seen);
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    stim_entry_t sync_e;
    int unsigned g;
    int unsigned v;
    int unsigned u;
    int unsigned pick;
    int unsigned cnt;
    int unsigned gen_n;
    int unsigned wmax;
    bit          linked;

    // full count, start 0: parallel edges, self-loop, empty item, extremes
    push_edge(0, 1, 16'hFFFF, 1, 0);
    push_edge(1, 2, 0, 1, 0);
    push_edge(1, 0, 5, 1, 0);
    push_edge(0, 1, 9, 1, 0);
    push_edge(3, 3, 7, 1, 0);
    push_edge(63, 62, 1234, 1, 0);
    push_edge(42, 21, 16'h5555, 0, 0);
    push_edge(21, 42, 16'hAAAA, 1, 0);
    push_edge(62, 63, 16'hAAAA, 1, 1);
    // three vertices, connected, with out-of-range edges and a bad self-loop
    push_cfg(CFG_VERTEX_COUNT, 3);
    push_edge(0, 1, 4, 1, 0);
    push_edge(1, 2, 6, 1, 0);
    push_edge(2, 0, 3, 1, 0);
    push_edge(5, 1, 1, 1, 0);
    push_edge(7, 7, 2, 1, 0);
    push_edge(0, 0, 0, 0, 1);
    // count lowered after loading
    push_cfg(CFG_VERTEX_COUNT, 4);
    push_edge(0, 1, 1, 1, 0);
    push_edge(1, 2, 2, 1, 0);
    push_edge(2, 3, 3, 1, 0);
    push_cfg(CFG_VERTEX_COUNT, 2);
    push_edge(0, 0, 0, 0, 1);
    // start beyond the count
    push_cfg(CFG_START_VERTEX, 5);
    push_edge(0, 1, 8, 1, 1);
    // zero count acts as one vertex
    push_cfg(CFG_VERTEX_COUNT, 0);
    push_cfg(CFG_START_VERTEX, 0);
    push_edge(1, 0, 3, 1, 0);
    push_edge(0, 0, 9, 1, 1);
    // count above the maximum, start with its top bit set
    push_cfg(CFG_VERTEX_COUNT, 127);
    push_cfg(CFG_START_VERTEX, 127);
    push_edge(63, 0, 2, 1, 1);
    gen_n = NV;

    // random graphs: mostly spanning trees with extras, some noise
    for (g = 0; items_queued < 900 || g < 48; g++) begin
      if (g == 0 || $urandom_range(1) == 1) begin
        pick = $urandom_range(99);
        if (pick < 3) cnt = 0;
        else if (pick < 6) cnt = 1;
        else if (pick < 9) cnt = NV;
        else if (pick < 11) cnt = $urandom_range(127, NV + 1);
        else if (pick < 20) cnt = $urandom_range(40, 13);
        else cnt = $urandom_range(12, 2);
        gen_n = (cnt == 0) ? 1 : ((cnt > NV) ? NV : cnt);
        push_cfg(CFG_VERTEX_COUNT, cnt);
        push_cfg(CFG_START_VERTEX,
                 ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(gen_n - 1));
      end else if ($urandom_range(2) == 0) begin
        // hold the sender until the previous graph has been answered
        sync_e.kind = ENT_SYNC;
        pending.insert(pending.size(), sync_e);
      end
      wmax   = ($urandom_range(2) == 0) ? 15 : 65535;
      linked = ($urandom_range(4) != 0);
      for (v = 1; v < gen_n; v++) begin
        if (linked || $urandom_range(5) != 0) begin
          u = $urandom_range(v - 1);
          if ($urandom_range(1) == 1) push_edge(v, u, $urandom_range(wmax), 1, 0);
          else push_edge(u, v, $urandom_range(wmax), 1, 0);
        end
        if ($urandom_range(3) == 0) begin
          push_edge($urandom_range(gen_n - 1), $urandom_range(gen_n - 1),
                    $urandom_range(wmax), 1, 0);
        end
        if ($urandom_range(15) == 0) begin
          if ($urandom_range(1) == 0) begin
            push_edge($urandom_range(63), $urandom_range(63), $urandom_range(65535), 0, 0);
          end else if (gen_n < NV) begin
            if ($urandom_range(1) == 0)
              push_edge($urandom_range(63, gen_n), $urandom_range(63),
                        $urandom_range(wmax), 1, 0);
            else
              push_edge($urandom_range(63), $urandom_range(63, gen_n),
                        $urandom_range(wmax), 1, 0);
          end
        end
      end
      push_edge($urandom_range(gen_n - 1), $urandom_range(gen_n - 1),
                $urandom_range(wmax), ($urandom_range(1) == 1), 1);
    end

    // reset, then wait for the stimulus and every result
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (items_taken != items_queued) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pmw_pkg.sv
rtl/pmw_adj_store.sv
rtl/pmw_tree.sv
rtl/prim_mst_weight_core.sv
test/prim_mst_weight_core_tb.sv
